// ===== rtl/mtrm_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the ring modulator.
package mtrm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int NOTE_BITS      = 7;
    localparam int FREQ_BITS      = 32;
    localparam int NOTE_FREQ_BITS = 30;
    localparam int CAR_FRAC       = 23;
    localparam int CAR_MAG_BITS   = CAR_FRAC + 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 36;
    localparam int DETUNE_BITS    = 17;
    localparam int MIX_BITS       = 17;
    localparam int GAIN_BITS      = 16;
    localparam int PPH_BITS       = 36;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // item kinds
    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_MIDI  = 1'b1;

    // MIDI message types (upper nibble of status) and the all-notes-off controller
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_CONTROL  = 4'hB;
    localparam logic [NOTE_BITS-1:0] CC_ALL_NOTES_OFF = 7'd123;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_NOTE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DETUNE       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIX          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_PER_HZ = 3'd4;

    // reset values
    localparam logic [NOTE_BITS-1:0]   BASE_NOTE_RESET = 7'd57;
    localparam logic [DETUNE_BITS-1:0] DETUNE_RESET    = 17'd65536;
    localparam logic [MIX_BITS-1:0]    MIX_RESET       = 17'd65536;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET      = 16'd16384;
    localparam logic [PPH_BITS-1:0]    PPH_RESET       = 36'd6382652536;
    localparam logic [FREQ_BITS-1:0]   FREQ_RESET      = 32'd14417920;

    // limits and coefficients
    localparam logic [MIX_BITS-1:0]  MIX_FULL   = 17'd65536;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [14:0]          GLIDE_COEF = 15'd25166;  // 0.0015 in Q0.24

    typedef struct packed {
        logic                   kind;
        sample_t                left_in;
        sample_t                right_in;
        logic [7:0]             status_byte;
        logic [NOTE_BITS-1:0]   note_number;
        logic [NOTE_BITS-1:0]   velocity;
    } in_item_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
    } out_item_t;

    typedef struct packed {
        logic [NOTE_BITS-1:0] note;
        sample_t              left;
        sample_t              right;
    } queue_entry_t;

    typedef struct packed {
        logic [DETUNE_BITS-1:0] detune_ratio;
        logic [MIX_BITS-1:0]    mix_level;
        logic [GAIN_BITS-1:0]   gain_level;
        logic [PPH_BITS-1:0]    phase_per_hz;
    } back_cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_TARGET,
        BK_DIFF,
        BK_GLIDE,
        BK_PHASE,
        BK_ROM,
        BK_WET,
        BK_TOTAL,
        BK_SCALE,
        BK_OUT
    } bk_state_t;

    // 7040 * 2^(k/12) Hz in Q16.16
    localparam logic [31:0] NOTE_BASE [12] = '{
        32'd461373440, 32'd488808132, 32'd517874176, 32'd548668578,
        32'd581294109, 32'd615859655, 32'd652480576, 32'd691279090,
        32'd732384684, 32'd775934544, 32'd822074013, 32'd870957077
    };

    typedef logic [NOTE_FREQ_BITS-1:0] note_tab_t [128];

    // note n -> Q16.16 frequency, shifted down by octave
    function automatic note_tab_t build_note_tab();
        note_tab_t tab;
        int        d;
        for (int i = 0; i < 128; i++)
        begin
            d      = i + 3;
            tab[i] = NOTE_FREQ_BITS'(NOTE_BASE[d % 12] >> (10 - d / 12));
        end
        return tab;
    endfunction

    localparam note_tab_t NOTE_FREQ = build_note_tab();

    // sine polynomial coefficients, Q30
    localparam longint SIN_C1 = 64'sd1686629713;
    localparam longint SIN_C3 = -64'sd693598669;
    localparam longint SIN_C5 = 64'sd85569306;
    localparam longint SIN_C7 = -64'sd5026995;
    localparam longint SIN_C9 = 64'sd172272;

    // round(a*b / 2^sh), half away from zero
    function automatic longint mul_round(longint a, longint b, int sh);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m  = (ma * mb + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // quarter-wave sine magnitude at step u of 2^qb, Q1.23
    function automatic logic [CAR_MAG_BITS-1:0] sine_mag(int u, int qb);
        longint x;
        longint x2;
        longint p;
        longint y;
        x  = longint'(u) << (30 - qb);
        x2 = mul_round(x, x, 30);
        p  = SIN_C9;
        p  = SIN_C7 + mul_round(p, x2, 30);
        p  = SIN_C5 + mul_round(p, x2, 30);
        p  = SIN_C3 + mul_round(p, x2, 30);
        p  = SIN_C1 + mul_round(p, x2, 30);
        y  = mul_round(p, x, 30);
        if (y < 0)
        begin
            y = 0;
        end
        if (y > (64'sd1 <<< 30))
        begin
            y = 64'sd1 <<< 30;
        end
        return CAR_MAG_BITS'((y + 64) >>> 7);
    endfunction

endpackage

// ===== rtl/mtrm_queue.sv =====
// Two-entry queue between the front end and the processing back end.
module mtrm_queue
    import mtrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output queue_entry_t head
);

    localparam int DEPTH = 2;

    queue_entry_t slots [DEPTH];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/mtrm_front.sv =====
// Front end: takes items, tracks the held MIDI note, queues audio pairs with their note.
module mtrm_front
    import mtrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    input  logic [NOTE_BITS-1:0] base_note,
    input  logic                 queue_full,
    output logic                 push,
    output queue_entry_t         push_entry
);

    logic                 held_valid_reg;
    logic                 held_valid_next;
    logic [NOTE_BITS-1:0] held_note_reg;
    logic [NOTE_BITS-1:0] held_note_next;
    logic                 accept;
    logic                 note_match;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign push       = accept && (item.kind == KIND_AUDIO);
    assign note_match = held_valid_reg && (held_note_reg == item.note_number);

    // note is resolved here so later MIDI traffic cannot reach queued pairs
    assign push_entry.note  = held_valid_reg ? held_note_reg : base_note;
    assign push_entry.left  = item.left_in;
    assign push_entry.right = item.right_in;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_note_next  = held_note_reg;
        if (accept && (item.kind == KIND_MIDI))
        begin
            case (item.status_byte[7:4])
                MIDI_NOTE_ON:
                begin
                    if (item.velocity != '0)
                    begin
                        held_valid_next = 1'b1;
                        held_note_next  = item.note_number;
                    end
                    else if (note_match)
                    begin
                        held_valid_next = 1'b0;
                    end
                end
                MIDI_NOTE_OFF:
                begin
                    if (note_match)
                    begin
                        held_valid_next = 1'b0;
                    end
                end
                MIDI_CONTROL:
                begin
                    if (item.note_number == CC_ALL_NOTES_OFF)
                    begin
                        held_valid_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_note_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_note_reg  <= held_note_next;
        end
    end

endmodule

// ===== rtl/mtrm_back.sv =====
// Back end: glide, NCO, sine ROM, stereo mix; one step per cycle unless output stalls.
module mtrm_back
    import mtrm_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  back_cfg_t    cfg,
    input  logic         entry_valid,
    input  queue_entry_t entry,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output out_item_t    result
);

    localparam int SB           = SAMPLE_BITS;
    localparam int QB           = SINE_ADDR_BITS - 2;
    localparam int QUARTER      = 1 << QB;
    localparam int ROM_DEPTH    = QUARTER + 1;
    localparam int ROM_IDX_BITS = SINE_ADDR_BITS - 1;
    localparam int INC_BITS     = 37;
    localparam int ACC_BITS     = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;
    localparam int WET_BITS     = SB + CAR_MAG_BITS;
    localparam int TOT_BITS     = SB + 18;
    localparam int MAG_BITS     = SB + 17;
    localparam int SCALE_BITS   = MAG_BITS + GAIN_BITS;
    localparam int RND_BITS     = SCALE_BITS - 29;

    localparam logic [RND_BITS-1:0] NEG_LIMIT = RND_BITS'(1) << (SB - 1);
    localparam logic [RND_BITS-1:0] POS_LIMIT = NEG_LIMIT - RND_BITS'(1);

    typedef logic [CAR_MAG_BITS-1:0] sine_rom_t [ROM_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = sine_mag(i, QB);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // control and running state
    bk_state_t               state_reg;
    bk_state_t               state_next;
    logic [FREQ_BITS-1:0]    freq_reg;
    logic [PHASE_BITS-1:0]   phase_reg;
    logic                    out_valid_reg;
    logic                    load_out;

    // per-item payload
    logic [NOTE_FREQ_BITS-1:0] note_f_reg;
    logic [FREQ_BITS-1:0]      target_reg;
    logic [FREQ_BITS-1:0]      diff_reg;
    logic                      up_reg;
    logic [CAR_MAG_BITS-1:0]   rom_data_reg;
    logic                      car_neg_reg;
    sample_t                   dry_reg       [2];
    logic [SB-1:0]             wet_mag_reg   [2];
    logic                      wet_neg_reg   [2];
    logic signed [TOT_BITS-1:0] total_reg    [2];
    logic [SCALE_BITS-1:0]     scale_reg     [2];
    logic                      scale_neg_reg [2];
    out_item_t                 out_reg;

    // datapath
    logic [46:0]               tgt_prod;
    logic [46:0]               tgt_sum;
    logic [FREQ_BITS-1:0]      target_next;
    logic [46:0]               glide_prod;
    logic [47:0]               glide_sum;
    logic [23:0]               glide_step;
    logic [FREQ_BITS-1:0]      freq_glide;
    logic [63:0]               inc_lo_prod;
    logic [35:0]               inc_hi_prod;
    logic [INC_BITS-1:0]       inc;
    logic [ACC_BITS-1:0]       phase_sum;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [1:0]                quad;
    logic [ROM_IDX_BITS-1:0]   rom_idx;
    logic [MIX_BITS-1:0]       mix_eff;
    logic [MIX_BITS-1:0]       dry_weight;
    logic [GAIN_BITS-1:0]      gain_eff;

    logic                      dry_neg      [2];
    logic [SB-1:0]             dry_mag      [2];
    logic [WET_BITS-1:0]       wet_prod     [2];
    logic [WET_BITS-1:0]       wet_sum      [2];
    logic signed [TOT_BITS-1:0] dry_x       [2];
    logic signed [TOT_BITS-1:0] wet_x       [2];
    logic signed [TOT_BITS-1:0] total_next  [2];
    logic                      tot_neg      [2];
    logic [TOT_BITS-1:0]       tot_abs      [2];
    logic [SCALE_BITS-1:0]     scale_next   [2];
    logic [SCALE_BITS:0]       rnd_sum      [2];
    logic [RND_BITS-1:0]       rnd_mag      [2];
    sample_t                   sat_out      [2];

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (entry_valid)
                begin
                    pop        = 1'b1;
                    state_next = BK_TARGET;
                end
            end
            BK_TARGET: state_next = BK_DIFF;
            BK_DIFF:   state_next = BK_GLIDE;
            BK_GLIDE:  state_next = BK_PHASE;
            BK_PHASE:  state_next = BK_ROM;
            BK_ROM:    state_next = BK_WET;
            BK_WET:    state_next = BK_TOTAL;
            BK_TOTAL:  state_next = BK_SCALE;
            BK_SCALE:  state_next = BK_OUT;
            BK_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // frequency: target, distance, glide
    always_comb
    begin
        tgt_prod    = 47'(note_f_reg) * 47'(cfg.detune_ratio);
        tgt_sum     = tgt_prod + 47'(32768);
        target_next = FREQ_BITS'(tgt_sum[46:16]);
        glide_prod  = 47'(diff_reg) * 47'(GLIDE_COEF);
        glide_sum   = 48'(glide_prod) + 48'(1 << 23);
        glide_step  = glide_sum[47:24];
        freq_glide  = up_reg ? (freq_reg + FREQ_BITS'(glide_step))
                             : (freq_reg - FREQ_BITS'(glide_step));
    end

    // phase increment = floor(freq * phase_per_hz / 2^32)
    always_comb
    begin
        inc_lo_prod = 64'(freq_reg) * 64'(cfg.phase_per_hz[31:0]);
        inc_hi_prod = 36'(freq_reg) * 36'(cfg.phase_per_hz[PPH_BITS-1:32]);
        inc         = INC_BITS'(inc_hi_prod) + INC_BITS'(inc_lo_prod[63:32]);
        phase_sum   = ACC_BITS'(phase_reg) + ACC_BITS'(inc);
    end

    // quarter-wave addressing; upper half of the turn is negated
    always_comb
    begin
        sine_addr = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
        rom_idx   = quad[0] ? (ROM_IDX_BITS'(QUARTER) - ROM_IDX_BITS'(sine_addr[QB-1:0]))
                            : ROM_IDX_BITS'(sine_addr[QB-1:0]);
    end

    // per-lane mix math, all rounding on magnitudes (half away from zero)
    always_comb
    begin
        mix_eff    = (cfg.mix_level > MIX_FULL) ? MIX_FULL : cfg.mix_level;
        dry_weight = MIX_FULL - mix_eff;
        gain_eff   = (cfg.gain_level > GAIN_MAX) ? GAIN_MAX : cfg.gain_level;
        for (int l = 0; l < 2; l++)
        begin
            dry_neg[l]  = dry_reg[l][SB-1];
            dry_mag[l]  = dry_neg[l] ? (~dry_reg[l] + SB'(1)) : dry_reg[l];
            wet_prod[l] = WET_BITS'(dry_mag[l]) * WET_BITS'(rom_data_reg);
            wet_sum[l]  = wet_prod[l] + WET_BITS'(1 << (CAR_FRAC - 1));

            dry_x[l] = TOT_BITS'(dry_reg[l]);
            wet_x[l] = TOT_BITS'(wet_mag_reg[l]);
            if (wet_neg_reg[l])
            begin
                wet_x[l] = -wet_x[l];
            end
            total_next[l] = dry_x[l] * $signed(TOT_BITS'(dry_weight))
                          + wet_x[l] * $signed(TOT_BITS'(mix_eff));

            tot_neg[l]    = total_reg[l][TOT_BITS-1];
            tot_abs[l]    = tot_neg[l] ? TOT_BITS'(-total_reg[l]) : TOT_BITS'(total_reg[l]);
            scale_next[l] = SCALE_BITS'(tot_abs[l][MAG_BITS-1:0]) * SCALE_BITS'(gain_eff);

            rnd_sum[l] = (SCALE_BITS+1)'(scale_reg[l]) + (SCALE_BITS+1)'(1 << 29);
            rnd_mag[l] = rnd_sum[l][SCALE_BITS:30];
            if (scale_neg_reg[l])
            begin
                sat_out[l] = (rnd_mag[l] >= NEG_LIMIT) ? SAMPLE_MIN : -SB'(rnd_mag[l]);
            end
            else
            begin
                sat_out[l] = (rnd_mag[l] > POS_LIMIT) ? SAMPLE_MAX : SB'(rnd_mag[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            freq_reg      <= FREQ_RESET;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_GLIDE)
            begin
                freq_reg <= freq_glide;
            end
            if (state_reg == BK_PHASE)
            begin
                phase_reg <= phase_sum[PHASE_BITS-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                note_f_reg <= NOTE_FREQ[entry.note];
                dry_reg[0] <= entry.left;
                dry_reg[1] <= entry.right;
            end
            BK_TARGET:
            begin
                target_reg <= target_next;
            end
            BK_DIFF:
            begin
                up_reg   <= (target_reg >= freq_reg);
                diff_reg <= (target_reg >= freq_reg) ? (target_reg - freq_reg)
                                                     : (freq_reg - target_reg);
            end
            BK_ROM:
            begin
                rom_data_reg <= SINE_ROM[rom_idx];
                car_neg_reg  <= quad[1];
            end
            BK_WET:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    wet_mag_reg[l] <= wet_sum[l][CAR_FRAC +: SB];
                    wet_neg_reg[l] <= dry_neg[l] ^ car_neg_reg;
                end
            end
            BK_TOTAL:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    total_reg[l] <= total_next[l];
                end
            end
            BK_SCALE:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    scale_reg[l]     <= scale_next[l];
                    scale_neg_reg[l] <= tot_neg[l];
                end
            end
            BK_OUT:
            begin
                if (load_out)
                begin
                    out_reg.left_out  <= sat_out[0];
                    out_reg.right_out <= sat_out[1];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/midi_tuned_stereo_ring_modulator_unit.sv =====
// Top level: MIDI-tuned stereo ring modulator with config registers, front end, queue, back end.
// An audio pair accepted into an empty block goes through the queue, then the back-end states
//   from target through output, before its result shows. The back-end sequencer takes one pair
//   at a time and finishes it before popping the next; MIDI transactions give no result.
// The two-entry queue lets the front take up to two pairs while the back end is busy.
// Reset (async, active low): no note held, glide at 220 Hz, phase zero, registers at defaults;
//   there is no clearing pass, the block is ready on the first cycle after reset.
module midi_tuned_stereo_ring_modulator_unit
    import mtrm_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  in_item_t                  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output out_item_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    logic [NOTE_BITS-1:0] base_note_reg;
    back_cfg_t            back_cfg_reg;

    // front <-> queue <-> back
    logic                 push;
    queue_entry_t         push_entry;
    logic                 queue_full;
    logic                 queue_empty;
    logic                 pop;
    queue_entry_t         head;

    // writes are always taken; an index beyond the register list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_note_reg             <= BASE_NOTE_RESET;
            back_cfg_reg.detune_ratio <= DETUNE_RESET;
            back_cfg_reg.mix_level    <= MIX_RESET;
            back_cfg_reg.gain_level   <= GAIN_RESET;
            back_cfg_reg.phase_per_hz <= PPH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_NOTE:    base_note_reg             <= cfg_data[NOTE_BITS-1:0];
                CFG_DETUNE:       back_cfg_reg.detune_ratio <= cfg_data[DETUNE_BITS-1:0];
                CFG_MIX:          back_cfg_reg.mix_level    <= cfg_data[MIX_BITS-1:0];
                CFG_GAIN:         back_cfg_reg.gain_level   <= cfg_data[GAIN_BITS-1:0];
                CFG_PHASE_PER_HZ: back_cfg_reg.phase_per_hz <= cfg_data[PPH_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end: MIDI note tracking, each audio pair is tagged with its carrier note
    mtrm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .base_note  (base_note_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples transaction intake from the multi-cycle back end
    mtrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    // back end: note to frequency, glide, NCO, sine ROM, wet/dry mix, gain, saturation;
    // the result sits in an output register so the next pair can proceed
    mtrm_back #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg_reg),
        .entry_valid  (!queue_empty),
        .entry        (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== dv/midi_tuned_stereo_ring_modulator_unit_tb.sv =====
// Self-checking testbench for the MIDI-tuned stereo ring modulator unit.
module midi_tuned_stereo_ring_modulator_unit_tb
    import mtrm_pkg::*;
();

    // The block is built with its default carrier geometry; the predictor uses the same.
    localparam int SINE_ADDR_BITS = 10;
    localparam int PHASE_BITS     = 32;
    localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;

    // Quiet stretch after the last result, before the registers are touched.
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_CYCLES  = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_PRINTED   = 40;

    // Message types the block should ignore, and a controller that is not all-notes-off.
    localparam logic [3:0]           MIDI_POLY_AT = 4'hA;
    localparam logic [3:0]           MIDI_SYSTEM  = 4'hF;
    localparam logic [NOTE_BITS-1:0] CC_VOLUME    = 7'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    in_item_t                  item;
    logic                      result_valid;
    logic                      result_ready;
    out_item_t                 result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Shadow of the block's registers, as the predictor sees them.
    logic [NOTE_BITS-1:0]   base_note_r = BASE_NOTE_RESET;
    logic [DETUNE_BITS-1:0] detune_r    = DETUNE_RESET;
    logic [MIX_BITS-1:0]    mix_r       = MIX_RESET;
    logic [GAIN_BITS-1:0]   gain_r      = GAIN_RESET;
    logic [PPH_BITS-1:0]    pph_r       = PPH_RESET;

    // Shadow of the block's carrier state.
    bit                     note_held  = 1'b0;
    logic [NOTE_BITS-1:0]   held_key   = '0;
    logic [FREQ_BITS-1:0]   glide_freq = FREQ_RESET;
    logic [PHASE_BITS-1:0]  nco_phase  = '0;

    // Output pairs predicted for accepted audio transactions, oldest first.
    out_item_t awaited_pairs[$];

    int error_count  = 0;
    int send_gap_pct = 37;
    int recv_gap_pct = 67;
    bit long_stall   = 1'b0;

    // Stimulus-side memory of the last note switched on, so note-offs can hit it.
    logic [NOTE_BITS-1:0] last_on_note = '0;

    midi_tuned_stereo_ring_modulator_unit #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor arithmetic
    //------------------------------------------------------------------

    // a*b / 2^sh, rounded half away from zero; the magnitude product must fit 64 bits.
    function automatic longint round_mul(longint a, longint b, int sh);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned um;
        bit              flip;
        flip = (a < 0) != (b < 0);
        ua   = (a < 0) ? $unsigned(-a) : $unsigned(a);
        ub   = (b < 0) ? $unsigned(-b) : $unsigned(b);
        um   = (ua * ub + (64'd1 << (sh - 1))) >> sh;
        return flip ? -$signed(um) : $signed(um);
    endfunction

    // Carrier sample in Q1.23 for one sine address: odd polynomial on a quarter wave.
    function automatic longint carrier_at(logic [SINE_ADDR_BITS-1:0] addr);
        logic [1:0] quad;
        longint     u;
        longint     x;
        longint     x2;
        longint     acc;
        longint     y;
        longint     c;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        u    = addr[QUARTER_BITS-1:0];
        if (quad[0])
        begin
            u = (longint'(1) << QUARTER_BITS) - u;
        end
        x   = u << (30 - QUARTER_BITS);
        x2  = round_mul(x, x, 30);
        acc = SIN_C9;
        acc = SIN_C7 + round_mul(acc, x2, 30);
        acc = SIN_C5 + round_mul(acc, x2, 30);
        acc = SIN_C3 + round_mul(acc, x2, 30);
        acc = SIN_C1 + round_mul(acc, x2, 30);
        y   = round_mul(acc, x, 30);
        if (y < 0)
        begin
            y = 0;
        end
        if (y > (longint'(1) << 30))
        begin
            y = longint'(1) << 30;
        end
        c = (y + 64) >>> 7;
        return quad[1] ? -c : c;
    endfunction

    // Equal-tempered note frequency in Q16.16, from the top-octave table shifted down.
    function automatic logic [63:0] note_freq_q16(logic [NOTE_BITS-1:0] n);
        int d;
        d = int'(n) + 3;
        return {32'd0, NOTE_BASE[d % 12]} >> (10 - d / 12);
    endfunction

    // One channel: dry/wet blend, gain, round and saturate.
    function automatic sample_t mix_one(sample_t dry_s, longint car, longint m, longint g);
        longint dry;
        longint wet;
        longint total;
        longint v;
        dry   = longint'($signed(dry_s));
        wet   = round_mul(dry, car, CAR_FRAC);
        total = dry * (65536 - m) + wet * m;
        v     = round_mul(total, g, 30);
        if (v > longint'(SAMPLE_MAX))
        begin
            v = longint'(SAMPLE_MAX);
        end
        if (v < longint'(SAMPLE_MIN))
        begin
            v = longint'(SAMPLE_MIN);
        end
        return sample_t'(v);
    endfunction

    // Note hold tracking; the channel nibble is don't-care.
    task automatic follow_midi(input in_item_t it);
        logic [3:0] msg;
        msg = it.status_byte[7:4];
        if (msg == MIDI_NOTE_ON && it.velocity != 0)
        begin
            note_held = 1'b1;
            held_key  = it.note_number;
        end
        else if (msg == MIDI_NOTE_OFF || (msg == MIDI_NOTE_ON && it.velocity == 0))
        begin
            if (note_held && held_key == it.note_number)
            begin
                note_held = 1'b0;
            end
        end
        else if (msg == MIDI_CONTROL && it.note_number == CC_ALL_NOTES_OFF)
        begin
            note_held = 1'b0;
        end
    endtask

    // Glide, NCO step and mixing for one audio pair.
    task automatic advance_and_modulate(input in_item_t it, output out_item_t pair);
        logic [63:0] target;
        logic [63:0] s;
        logic [63:0] step;
        logic [63:0] inc;
        longint      car;
        longint      m;
        longint      g;
        target = (note_freq_q16(note_held ? held_key : base_note_r) * 64'(detune_r)
                  + 64'd32768) >> 16;
        if (target > 64'hFFFF_FFFF)
        begin
            target = 64'hFFFF_FFFF;
        end
        s = 64'(glide_freq);
        if (target >= s)
        begin
            step = ((target - s) * 64'(GLIDE_COEF) + (64'd1 << 23)) >> 24;
            s    = s + step;
        end
        else
        begin
            step = ((s - target) * 64'(GLIDE_COEF) + (64'd1 << 23)) >> 24;
            s    = s - step;
        end
        glide_freq = s[FREQ_BITS-1:0];
        // Q16.16 frequency times Q20.16 phase-per-Hz, keeping the integer phase step
        inc = 64'(glide_freq) * 64'(pph_r[PPH_BITS-1:32])
            + ((64'(glide_freq) * 64'(pph_r[31:0])) >> 32);
        nco_phase = nco_phase + inc[PHASE_BITS-1:0];
        car = carrier_at(nco_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]);
        m   = (mix_r > MIX_FULL) ? longint'(MIX_FULL) : longint'(mix_r);
        g   = (gain_r > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_r);
        pair.left_out  = mix_one(it.left_in, car, m, g);
        pair.right_out = mix_one(it.right_in, car, m, g);
    endtask

    task automatic take_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_BASE_NOTE:    base_note_r = data[NOTE_BITS-1:0];
            CFG_DETUNE:       detune_r    = data[DETUNE_BITS-1:0];
            CFG_MIX:          mix_r       = data[MIX_BITS-1:0];
            CFG_GAIN:         gain_r      = data[GAIN_BITS-1:0];
            CFG_PHASE_PER_HZ: pph_r       = data[PPH_BITS-1:0];
            default:          ;
        endcase
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    //------------------------------------------------------------------
    // Monitor and checker: everything is sampled at the rising edge, before
    // this edge's nonblocking updates land, so handshakes are seen as the
    // block saw them. Results are checked before new predictions are queued.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t pair;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (awaited_pairs.size() == 0)
                begin
                    report_error($sformatf("result %h with nothing outstanding", result));
                end
                else
                begin
                    want = awaited_pairs.pop_front();
                    if (result.left_out !== want.left_out)
                    begin
                        report_error($sformatf("left_out %0d, predicted %0d",
                                     $signed(result.left_out), $signed(want.left_out)));
                    end
                    if (result.right_out !== want.right_out)
                    begin
                        report_error($sformatf("right_out %0d, predicted %0d",
                                     $signed(result.right_out), $signed(want.right_out)));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                take_register(cfg_index, cfg_data);
            end
            if (item_valid && item_ready)
            begin
                if (item.kind == KIND_MIDI)
                begin
                    follow_midi(item);
                end
                else
                begin
                    advance_and_modulate(item, pair);
                    awaited_pairs.push_back(pair);
                end
            end
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request so the
    // internal queue fills and item_ready drops.
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall)
            begin
                result_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                long_stall = 1'b0;
            end
            result_ready <= ($urandom_range(99, 0) >= recv_gap_pct);
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Audio pair; the MIDI fields are junk the block must ignore.
    function automatic in_item_t audio_item(sample_t l, sample_t r);
        in_item_t it;
        it.kind        = KIND_AUDIO;
        it.left_in     = l;
        it.right_in    = r;
        it.status_byte = 8'($urandom);
        it.note_number = NOTE_BITS'($urandom);
        it.velocity    = NOTE_BITS'($urandom);
        return it;
    endfunction

    // MIDI message on a random channel; sample fields carry junk.
    function automatic in_item_t midi_item(logic [3:0] msg, logic [NOTE_BITS-1:0] d1,
                                           logic [NOTE_BITS-1:0] d2);
        in_item_t it;
        it.kind        = KIND_MIDI;
        it.left_in     = sample_t'($urandom);
        it.right_in    = sample_t'($urandom);
        it.status_byte = {msg, 4'($urandom)};
        it.note_number = d1;
        it.velocity    = d2;
        return it;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(9, 0))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'($signed(9'($urandom)));
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Mostly audio; MIDI leans toward note on/off pairs that actually match.
    task automatic make_random_item(output in_item_t it);
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 62)
        begin
            it = audio_item(random_sample(), random_sample());
        end
        else if (pick < 74)
        begin
            last_on_note = NOTE_BITS'($urandom);
            it = midi_item(MIDI_NOTE_ON, last_on_note, NOTE_BITS'($urandom_range(127, 1)));
        end
        else if (pick < 82)
        begin
            it = midi_item(MIDI_NOTE_OFF, last_on_note, NOTE_BITS'($urandom));
        end
        else if (pick < 86)
        begin
            it = midi_item(MIDI_NOTE_ON, last_on_note, '0);
        end
        else if (pick < 89)
        begin
            it = midi_item(MIDI_NOTE_OFF, NOTE_BITS'($urandom), NOTE_BITS'($urandom));
        end
        else if (pick < 92)
        begin
            it = midi_item(MIDI_CONTROL, CC_ALL_NOTES_OFF, NOTE_BITS'($urandom));
        end
        else if (pick < 94)
        begin
            it = midi_item(MIDI_CONTROL, NOTE_BITS'($urandom), NOTE_BITS'($urandom));
        end
        else
        begin
            it = midi_item(4'($urandom), NOTE_BITS'($urandom), NOTE_BITS'($urandom));
        end
    endtask

    // One input transaction: optional random gap, then hold valid until accepted.
    // Returns in the cycle of acceptance; valid is left high for the caller.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    // One register write; cfg_valid stays high so writes can go back to back.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop offering input, wait for every predicted pair, then let the pipe go quiet.
    task automatic settle();
        int waited;
        item_valid <= 1'b0;
        waited = 0;
        while (awaited_pairs.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random register set between traffic chunks; sometimes out of range on purpose.
    task automatic randomize_registers();
        if ($urandom_range(9, 0) < 6)
        begin
            if ($urandom_range(3, 0) == 0)
                write_register(CFG_BASE_NOTE, CFG_DATA_BITS'({$urandom, $urandom}));
            else
                write_register(CFG_BASE_NOTE, CFG_DATA_BITS'($urandom_range(127, 0)));
        end
        if ($urandom_range(9, 0) < 6)
        begin
            case ($urandom_range(5, 0))
                0:       write_register(CFG_DETUNE, CFG_DATA_BITS'(61858));
                1:       write_register(CFG_DETUNE, CFG_DATA_BITS'(69433));
                2:       write_register(CFG_DETUNE, CFG_DATA_BITS'({$urandom, $urandom}));
                default: write_register(CFG_DETUNE, CFG_DATA_BITS'($urandom_range(69433, 61858)));
            endcase
        end
        if ($urandom_range(9, 0) < 6)
        begin
            case ($urandom_range(5, 0))
                0:       write_register(CFG_MIX, '0);
                1:       write_register(CFG_MIX, CFG_DATA_BITS'(MIX_FULL));
                2:       write_register(CFG_MIX, CFG_DATA_BITS'({$urandom, $urandom}));
                default: write_register(CFG_MIX, CFG_DATA_BITS'($urandom_range(65536, 0)));
            endcase
        end
        if ($urandom_range(9, 0) < 6)
        begin
            case ($urandom_range(5, 0))
                0:       write_register(CFG_GAIN, '0);
                1:       write_register(CFG_GAIN, CFG_DATA_BITS'(GAIN_MAX));
                2:       write_register(CFG_GAIN, CFG_DATA_BITS'({$urandom, $urandom}));
                default: write_register(CFG_GAIN, CFG_DATA_BITS'($urandom_range(32768, 0)));
            endcase
        end
        if ($urandom_range(9, 0) < 6)
        begin
            case ($urandom_range(7, 0))
                0:       write_register(CFG_PHASE_PER_HZ, '0);
                1:       write_register(CFG_PHASE_PER_HZ, CFG_DATA_BITS'({$urandom, $urandom}));
                default: write_register(CFG_PHASE_PER_HZ,
                                        {4'($urandom_range(8, 0)), 32'($urandom)});
            endcase
        end
        // unmapped index: must leave every register alone
        if ($urandom_range(9, 0) == 0)
        begin
            write_register(CFG_INDEX_BITS'($urandom_range(2**CFG_INDEX_BITS - 1,
                                                          CFG_PHASE_PER_HZ + 1)),
                           CFG_DATA_BITS'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Full-scale and near-zero samples at reset settings (fully wet, unity gain).
    task automatic test_sample_extremes();
        send_item(audio_item(SAMPLE_MAX, SAMPLE_MIN));
        send_item(audio_item(SAMPLE_MIN, SAMPLE_MAX));
        send_item(audio_item('0, '0));
        send_item(audio_item(-sample_t'(1), sample_t'(1)));
        settle();
    endtask

    // Note hold rules, each followed by audio so the carrier pitch shows the effect.
    task automatic test_midi_handling();
        send_item(midi_item(MIDI_NOTE_ON, 7'd69, 7'd100));
        send_item(audio_item(random_sample(), random_sample()));
        // note-off for a different note keeps the hold
        send_item(midi_item(MIDI_NOTE_OFF, 7'd60, 7'd64));
        send_item(audio_item(random_sample(), random_sample()));
        // note-on with zero velocity acts as note-off
        send_item(midi_item(MIDI_NOTE_ON, 7'd69, 7'd0));
        send_item(audio_item(random_sample(), random_sample()));
        send_item(midi_item(MIDI_NOTE_ON, 7'd127, 7'd127));
        send_item(midi_item(MIDI_CONTROL, CC_ALL_NOTES_OFF, 7'd0));
        send_item(audio_item(random_sample(), random_sample()));
        // lowest note and velocity; then messages that must be ignored
        send_item(midi_item(MIDI_NOTE_ON, 7'd0, 7'd1));
        send_item(midi_item(MIDI_CONTROL, CC_VOLUME, 7'd127));
        send_item(midi_item(MIDI_POLY_AT, 7'd0, 7'd127));
        send_item(midi_item(MIDI_SYSTEM, 7'd0, 7'd0));
        send_item(audio_item(random_sample(), random_sample()));
        send_item(midi_item(MIDI_NOTE_OFF, 7'd0, 7'd0));
        send_item(audio_item(SAMPLE_MAX, SAMPLE_MIN));
        settle();
    endtask

    // Register corners, including mix/gain above their clamp and a frozen phase.
    task automatic test_register_extremes();
        write_register(CFG_BASE_NOTE, '0);
        write_register(CFG_DETUNE, CFG_DATA_BITS'(61858));
        write_register(CFG_MIX, '0);
        write_register(CFG_GAIN, CFG_DATA_BITS'(GAIN_MAX));
        write_register(CFG_PHASE_PER_HZ, '0);
        cfg_valid <= 1'b0;
        send_item(audio_item(SAMPLE_MAX, SAMPLE_MIN));
        send_item(audio_item(random_sample(), random_sample()));
        settle();

        write_register(CFG_BASE_NOTE, CFG_DATA_BITS'(127));
        write_register(CFG_DETUNE, CFG_DATA_BITS'(69433));
        write_register(CFG_MIX, CFG_DATA_BITS'(17'h1FFFF));
        write_register(CFG_GAIN, CFG_DATA_BITS'(16'hFFFF));
        write_register(CFG_PHASE_PER_HZ, {CFG_DATA_BITS{1'b1}});
        cfg_valid <= 1'b0;
        send_item(audio_item(SAMPLE_MIN, SAMPLE_MAX));
        send_item(audio_item(random_sample(), random_sample()));
        settle();

        write_register(CFG_DETUNE, '0);
        write_register(CFG_MIX, CFG_DATA_BITS'(MIX_FULL));
        write_register(CFG_GAIN, '0);
        write_register(CFG_PHASE_PER_HZ, CFG_DATA_BITS'(1));
        cfg_valid <= 1'b0;
        send_item(audio_item(SAMPLE_MAX, SAMPLE_MAX));
        send_item(audio_item(random_sample(), random_sample()));
        settle();

        // detune far above its nominal range, half mix, and writes to unmapped indexes
        write_register(CFG_DETUNE, CFG_DATA_BITS'(17'h1FFFF));
        write_register(CFG_MIX, CFG_DATA_BITS'(32768));
        write_register(CFG_GAIN, CFG_DATA_BITS'(GAIN_RESET));
        write_register(CFG_PHASE_PER_HZ, PPH_RESET);
        for (int idx = CFG_PHASE_PER_HZ + 1; idx < 2**CFG_INDEX_BITS; idx++)
        begin
            write_register(CFG_INDEX_BITS'(idx), CFG_DATA_BITS'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
        send_item(audio_item(random_sample(), random_sample()));
        send_item(audio_item(SAMPLE_MIN, SAMPLE_MIN));
        settle();
    endtask

    // Output held off for a long stretch while input keeps coming: the block must
    // fill, drop item_ready, and lose nothing.
    task automatic test_output_stall();
        long_stall = 1'b1;
        repeat (30)
        begin
            send_item(audio_item(random_sample(), random_sample()));
        end
        settle();
    endtask

    // Random traffic in chunks, with fresh register settings between chunks.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int       sent;
        int       chunk;
        in_item_t it;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        sent = 0;
        while (sent < count)
        begin
            randomize_registers();
            chunk = $urandom_range(150, 50);
            if (chunk > count - sent)
            begin
                chunk = count - sent;
            end
            repeat (chunk)
            begin
                make_random_item(it);
                send_item(it);
            end
            sent += chunk;
            settle();
        end
    endtask

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial
    begin
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_sample_extremes();
        test_midi_handling();
        test_register_extremes();
        test_output_stall();
        test_random_traffic(37, 67, 620);
        test_random_traffic(67, 37, 620);
        test_random_traffic(0, 0, 620);

        if (awaited_pairs.size() != 0)
        begin
            report_error($sformatf("%0d predicted pairs never came out", awaited_pairs.size()));
        end
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
